### rtl/assert_macros.svh
// Assertion macros for the RTL of the keystream cipher (used by the back end).
// No dependencies; include by bare file name where checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that is off while reset is asserted
`define RKC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: check failed");
// Check that also holds through reset
`define RKC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: check failed");
`else
`define RKC_ASSERT(lbl, clk, rst_n, prop)
`define RKC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/rkc_pkg.sv
// Types and constants of the rolling keystream byte cipher.
// No dependencies; used by every other file of the block but assert_macros.svh.
package rkc_pkg;

    localparam int KEY_WORDS    = 4;
    localparam int WORD_BITS    = 64;
    localparam int KEY_BITS     = KEY_WORDS * WORD_BITS;
    localparam int CFG_IDX_W    = 8;
    localparam int FID_W        = 32;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Cipher constants
    localparam logic [7:0] SEED_XOR  = 8'h7E;
    localparam logic [7:0] IDX_ADD   = 8'h2D;
    localparam logic [7:0] IDX_MUL   = 8'd11;
    localparam logic [4:0] OFF_MUL   = 5'd3;
    localparam logic [7:0] ROLL_XOR  = 8'hA3;
    localparam logic [4:0] SEED_KEY_BYTE = 5'd1;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_WORD_0 = 8'd0,
        REG_KEY_WORD_1 = 8'd1,
        REG_KEY_WORD_2 = 8'd2,
        REG_KEY_WORD_3 = 8'd3
    } t_reg_idx;

    // Classified byte, as it travels from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic [7:0] seed;     // function id low byte, pre-mixed with SEED_XOR
        logic [4:0] offset;   // key offset for a new block
        logic       last;
    } t_item;

    // Byte pos of the key (little-endian over the words)
    function automatic logic [7:0] key_byte(input logic [KEY_BITS-1:0] key,
                                            input logic [4:0] pos);
        key_byte = key[{pos, 3'b000} +: 8];
    endfunction

endpackage

### rtl/rkc_if.sv
// Channel interfaces of the keystream cipher: byte input, byte output, config.
// Depends on rkc_pkg.
interface rkc_in_if;
    import rkc_pkg::*;
    logic             valid;
    logic             ready;
    logic [7:0]       data_in;
    logic             block_start;
    logic [FID_W-1:0] function_id;
    logic             block_end;

    modport source (output valid, data_in, block_start, function_id, block_end,
                    input ready);
    modport sink   (input valid, data_in, block_start, function_id, block_end,
                    output ready);
endinterface

interface rkc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;
    logic       last_out;

    modport source (output valid, data_out, last_out, input ready);
    modport sink   (input valid, data_out, last_out, output ready);
endinterface

interface rkc_cfg_if;
    import rkc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/rolling_keystream_byte_cipher.sv
// Path from input beat to output beat: front holding register, queue entry, output register.
// Throughput: one byte per cycle while the output is not stalled; the 8-bit rolling recurrence closes in the back end.
// A stalled output backs up through a 2-entry queue before the input is held off.
// Reset (synchronous, active low) clears key words, rolling value, index and offset.
// Top level of the keystream cipher; depends on rkc_pkg, rkc_if, front, queue, back.
module rolling_keystream_byte_cipher (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rkc_in_if.sink    i_data_ch,
    rkc_cfg_if.sink   i_cfg_ch,
    rkc_out_if.source o_data_ch
);
    import rkc_pkg::*;

    logic  q_push;
    t_item q_push_item;
    logic  q_ready;
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    rkc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_data_ch),
        .i_q_ready(q_ready),
        .o_q_push (q_push),
        .o_q_item (q_push_item)
    );

    rkc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_item(q_push_item),
        .o_ready    (q_ready),
        .o_valid    (q_valid),
        .o_item     (q_item),
        .i_pop      (q_pop)
    );

    rkc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg_ch),
        .i_q_valid(q_valid),
        .i_q_item (q_item),
        .o_q_pop  (q_pop),
        .o_out    (o_data_ch)
    );
endmodule

### rtl/rkc_front.sv
// Front end: accepts input beats, classifies block starts and precomputes
// the seed byte and key offset. Depends on rkc_pkg and rkc_in_if.
module rkc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rkc_in_if.sink         i_in,
    input  logic           i_q_ready,
    output logic           o_q_push,
    output rkc_pkg::t_item o_q_item
);
    import rkc_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;

    assign i_in.ready = !r_valid || i_q_ready;
    assign accept     = i_in.valid && i_in.ready;

    // Classify the beat
    always_comb begin
        n_item.data   = i_in.data_in;
        n_item.start  = i_in.block_start;
        n_item.seed   = i_in.function_id[7:0] ^ SEED_XOR;
        n_item.offset = 5'(i_in.function_id[4:0] * OFF_MUL);
        n_item.last   = i_in.block_end;
    end

    // Holding stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_q_push = r_valid;
    assign o_q_item = r_item;
endmodule

### rtl/rkc_queue.sv
// Short queue between front and back end of the keystream cipher.
// Depends on rkc_pkg.
module rkc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rkc_pkg::t_item i_push_item,
    output logic           o_ready,
    output logic           o_valid,
    output rkc_pkg::t_item o_item,
    input  logic           i_pop
);
    import rkc_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push;
    logic               do_pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end
endmodule

### rtl/rkc_back.sv
// Back end: key registers, rolling state, keystream and output register.
// Depends on rkc_pkg, rkc_if and assert_macros.svh.
`include "assert_macros.svh"
module rkc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rkc_cfg_if.sink        i_cfg,
    input  logic           i_q_valid,
    input  rkc_pkg::t_item i_q_item,
    output logic           o_q_pop,
    rkc_out_if.source      o_out
);
    import rkc_pkg::*;

    logic [KEY_BITS-1:0] r_key;
    logic [7:0]          r_roll;
    logic [7:0]          r_idx;
    logic [4:0]          r_off;
    logic                r_out_valid;
    logic [7:0]          r_data_out;
    logic                r_last;

    logic [7:0] n_roll;
    logic [7:0] n_idx;
    logic [7:0] cur_roll;
    logic [7:0] cur_idx;
    logic [4:0] cur_off;
    logic [4:0] key_pos;
    logic [7:0] idx_mix;
    logic [7:0] ks;
    logic       pop;

    assign i_cfg.ready = 1'b1;
    assign pop         = i_q_valid && (!r_out_valid || o_out.ready);
    assign o_q_pop     = pop;

    // Key words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_KEY_WORD_0: r_key[0*WORD_BITS +: WORD_BITS] <= i_cfg.data;
                REG_KEY_WORD_1: r_key[1*WORD_BITS +: WORD_BITS] <= i_cfg.data;
                REG_KEY_WORD_2: r_key[2*WORD_BITS +: WORD_BITS] <= i_cfg.data;
                REG_KEY_WORD_3: r_key[3*WORD_BITS +: WORD_BITS] <= i_cfg.data;
                default:        r_key <= r_key;
            endcase
        end
    end

    // Seed on block start, else continue the chain
    always_comb begin
        if (i_q_item.start) begin
            cur_roll = i_q_item.seed ^ key_byte(r_key, SEED_KEY_BYTE);
            cur_idx  = '0;
            cur_off  = i_q_item.offset;
        end else begin
            cur_roll = r_roll;
            cur_idx  = r_idx;
            cur_off  = r_off;
        end
    end

    // Keystream byte and next rolling value
    assign key_pos = cur_idx[4:0] + cur_off;
    assign idx_mix = 8'(cur_idx * IDX_MUL + IDX_ADD);
    assign ks      = key_byte(r_key, key_pos) ^ cur_roll ^ idx_mix;
    assign n_roll  = 8'(cur_roll + cur_idx + 8'd1 + ks) ^ ROLL_XOR;
    assign n_idx   = cur_idx + 8'd1;

    // Chain state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll      <= '0;
            r_idx       <= '0;
            r_off       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_roll      <= n_roll;
                r_idx       <= n_idx;
                r_off       <= cur_off;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (pop) begin
            r_data_out <= i_q_item.data ^ ks;
            r_last     <= i_q_item.last;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.data_out = r_data_out;
    assign o_out.last_out = r_last;

    // Checks
    `RKC_ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !r_out_valid)
    `RKC_ASSERT(a_pop_fills_out, i_clk, i_rst_n, pop |=> r_out_valid)
    `RKC_ASSERT(a_start_idx, i_clk, i_rst_n, (pop && i_q_item.start) |=> (r_idx == 8'd1))
    `RKC_ASSERT(a_idx_step, i_clk, i_rst_n,
        (pop && !i_q_item.start) |=> (r_idx == 8'($past(r_idx) + 8'd1)))
    `RKC_ASSERT(a_hold_state, i_clk, i_rst_n, !pop |=> ($stable(r_roll) && $stable(r_idx)))
endmodule
